// File: design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the active-low reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/aes_ss_pkg.sv
// Package of the AES SubBytes/ShiftRows stage: item types, S-box tables and byte helpers.
package aes_ss_pkg;

    localparam int unsigned NumBytes = 16;
    localparam int unsigned HalfWidth = 64;

    typedef struct packed {
        logic [HalfWidth-1:0] block_high;
        logic [HalfWidth-1:0] block_low;
        logic                 decrypt;
    } in_item_t;

    typedef struct packed {
        logic [HalfWidth-1:0] result_high;
        logic [HalfWidth-1:0] result_low;
    } out_item_t;

    typedef logic [7:0] byte_t;

    localparam byte_t FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Source byte of output byte k for ShiftRows (5k mod 16) and InvShiftRows (13k mod 16).
    function automatic int unsigned fwd_src(input int unsigned k);
        return (5 * k) % NumBytes;
    endfunction

    function automatic int unsigned inv_src(input int unsigned k);
        return (13 * k) % NumBytes;
    endfunction

endpackage

// File: design/aes_ss_core.sv
// Combinational SubBytes/ShiftRows core: byte substitution followed by the byte permutation.
module aes_ss_core (
    input  aes_ss_pkg::in_item_t  item_in,
    output aes_ss_pkg::out_item_t item_out
);
    import aes_ss_pkg::*;

    logic [8*NumBytes-1:0] state_in;
    logic [8*NumBytes-1:0] state_out;
    byte_t                 sub_bytes [NumBytes];

    assign state_in = {item_in.block_high, item_in.block_low};

    // Byte i sits at the top end of the state, so byte 0 is bits 127 down to 120.
    for (genvar i = 0; i < NumBytes; i++) begin : g_sub
        localparam int unsigned Msb = 8 * (NumBytes - i) - 1;
        assign sub_bytes[i] = item_in.decrypt ? INV_SBOX[state_in[Msb -: 8]]
                                              : FWD_SBOX[state_in[Msb -: 8]];
    end

    for (genvar k = 0; k < NumBytes; k++) begin : g_shift
        localparam int unsigned Msb = 8 * (NumBytes - k) - 1;
        localparam int unsigned FwdIdx = fwd_src(k);
        localparam int unsigned InvIdx = inv_src(k);
        assign state_out[Msb -: 8] = item_in.decrypt ? sub_bytes[InvIdx] : sub_bytes[FwdIdx];
    end

    assign item_out.result_high = state_out[8*NumBytes-1 -: HalfWidth];
    assign item_out.result_low  = state_out[HalfWidth-1:0];

endmodule

// File: design/aes_subbytes_shiftrows_stage.sv
// Top level of the AES SubBytes/ShiftRows round stage with its input and result registers.
// This stage takes one 128-bit AES state per item, byte 0 in the top bits of
// block_high and byte 15 in the bottom bits of block_low, and returns the state
// after SubBytes and ShiftRows, or after the inverse S-box and InvShiftRows when
// decrypt is set. It accepts one item in every clock cycle while the downstream
// side keeps m_ready high, and passes each item through the input register and
// then the result register, with the sixteen table lookups and the byte permutation
// as the logic between them. Both registers stall in place while a result waits
// and the downstream side holds m_ready low, and an item can be accepted while a
// finished result still waits, so long as the input register is empty or empties
// into the result register in the same cycle. Reset clears only the two valid flags.
module aes_subbytes_shiftrows_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  aes_ss_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output aes_ss_pkg::out_item_t m_data
);
    import aes_ss_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_ready;
    logic      in_load;
    logic      out_load;

    // The result register can take a new item when it is empty or is being read
    // in this cycle; the input register likewise when it empties into it.
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign in_load   = s_valid && s_ready;
    assign out_load  = in_valid_reg && out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    aes_ss_core u_core (
        .item_in  (in_item_reg),
        .item_out (out_item_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; they only load alongside their valid flag.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= s_data;
        end
        if (out_load) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

// File: design/aes_ss_checker.sv
// Port-level checker of the AES SubBytes/ShiftRows stage and its bind statement.
`include "assert_macros.svh"

module aes_ss_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready
);

    // Reset empties the result register.
    `ASSERT_CLK(a_reset_empties, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A result rising from an empty output came through the input and result registers.
    `ASSERT_CLK_RST(a_latency, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready, 2), "result without matching item")

    // With nothing waiting at the output, the stage must be able to take an item.
    `ASSERT_CLK_RST(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready, "stage stalled while output empty")

    // A result that has not been taken stays on offer.
    `ASSERT_CLK_RST(a_valid_holds, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result withdrawn before accept")

endmodule

bind aes_subbytes_shiftrows_stage aes_ss_checker u_checker (.*);
